// ===== hw/rtl/stca_pkg.sv =====
// Package for the sprite tile clip and address unit.
// Holds field widths, configuration register indexes and reset values, and
// the divider depth and the stream data widths. No dependencies.
package stca_pkg;

    localparam int POS_W  = 16;
    localparam int IDX_W  = 12;
    localparam int SIZE_W = 9;
    localparam int GAP_W  = 8;
    localparam int PER_W  = 13;
    localparam int ADDR_W = 22;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_TILE_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHEET_MARGIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_SPACING  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TILES_PER_ROW = 3'd4;

    localparam logic [SIZE_W-1:0] TILE_WIDTH_RST    = 9'd16;
    localparam logic [SIZE_W-1:0] TILE_HEIGHT_RST   = 9'd16;
    localparam logic [GAP_W-1:0]  SHEET_MARGIN_RST  = 8'd0;
    localparam logic [GAP_W-1:0]  TILE_SPACING_RST  = 8'd0;
    localparam logic [PER_W-1:0]  TILES_PER_ROW_RST = 13'd1;

    localparam int DIV_STAGES = 4;

    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 96;

endpackage

// ===== hw/rtl/stca_div.sv =====
// Pipelined restoring divider for the tile index by the tiles per row.
// Depends on stca_pkg; each stage resolves a fixed group of quotient bits.
module stca_div #(
    parameter int STAGES = stca_pkg::DIV_STAGES
) (
    input  logic                        clk,
    input  logic [STAGES-1:0]           adv,
    input  logic [stca_pkg::IDX_W-1:0]  dividend,
    input  logic [stca_pkg::PER_W-1:0]  divisor,
    output logic [stca_pkg::IDX_W-1:0]  quotient,
    output logic [stca_pkg::PER_W-1:0]  remainder
);

    localparam int BPS = (stca_pkg::IDX_W + STAGES - 1) / STAGES;
    localparam int QW  = STAGES * BPS;
    localparam int RW  = stca_pkg::PER_W;

    logic [RW-1:0] rem_reg [STAGES];
    logic [QW-1:0] dq_reg  [STAGES];

    genvar s;
    generate
        for (s = 0; s < STAGES; s++)
        begin : g_stage
            logic [RW-1:0] rem_in;
            logic [QW-1:0] dq_in;
            logic [RW-1:0] rem_next;
            logic [QW-1:0] dq_next;

            if (s == 0)
            begin : g_first
                assign rem_in = '0;
                assign dq_in  = QW'(dividend);
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[s-1];
                assign dq_in  = dq_reg[s-1];
            end

            always_comb
            begin
                logic [RW:0] t;
                rem_next = rem_in;
                dq_next  = dq_in;
                for (int b = 0; b < BPS; b++)
                begin
                    t = {rem_next, dq_next[QW-1]};
                    if (t >= {1'b0, divisor})
                    begin
                        rem_next = RW'(t - {1'b0, divisor});
                        dq_next  = {dq_next[QW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = t[RW-1:0];
                        dq_next  = {dq_next[QW-2:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv[s])
                begin
                    rem_reg[s] <= rem_next;
                    dq_reg[s]  <= dq_next;
                end
            end
        end
    endgenerate

    assign quotient  = dq_reg[STAGES-1][stca_pkg::IDX_W-1:0];
    assign remainder = rem_reg[STAGES-1];

endmodule

// ===== hw/rtl/sprite_tile_clip_address_unit.sv =====
// Sprite tile clip and address unit: clips a sprite against a box and finds its sheet rectangle.
// Requests pass the input register, the divider stages, the product and the output registers.
// Throughput is one transaction per cycle unless the output stalls; the divider sets the depth.
// Stages stall independently, so an empty stage keeps taking input while a result waits.
// Reset clears all valid bits and loads the configuration registers with their defaults.
// Depends on stca_pkg and stca_div.
module sprite_tile_clip_address_unit #(
    parameter int DIV_STAGES = stca_pkg::DIV_STAGES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [stca_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [stca_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // pos_x, pos_y, tile_index, clip_left, clip_top, clip_right, clip_bottom, zero pad
    input  logic [stca_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // dest_x, dest_y, src_x, src_y, src_w, src_h, zero pad
    output logic [stca_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // visible
    output logic [0:0]                        m_axis_tuser
);

    localparam int NST  = DIV_STAGES + 3;
    localparam int MUL  = DIV_STAGES + 1;
    localparam int LAST = NST - 1;
    localparam int STEP_W = stca_pkg::SIZE_W + 1;

    typedef struct packed {
        logic signed [stca_pkg::POS_W-1:0] clip_bottom;
        logic signed [stca_pkg::POS_W-1:0] clip_right;
        logic signed [stca_pkg::POS_W-1:0] clip_top;
        logic signed [stca_pkg::POS_W-1:0] clip_left;
        logic        [stca_pkg::IDX_W-1:0] tile_index;
        logic signed [stca_pkg::POS_W-1:0] pos_y;
        logic signed [stca_pkg::POS_W-1:0] pos_x;
    } req_t;

    typedef struct packed {
        logic                               vis;
        logic signed [stca_pkg::POS_W-1:0]  dst;
        logic        [stca_pkg::SIZE_W-1:0] off;
        logic        [stca_pkg::SIZE_W-1:0] len;
    } axis_t;

    typedef struct packed {
        logic                               vis;
        logic signed [stca_pkg::POS_W-1:0]  dst_x;
        logic signed [stca_pkg::POS_W-1:0]  dst_y;
        logic        [stca_pkg::SIZE_W-1:0] off_x;
        logic        [stca_pkg::SIZE_W-1:0] off_y;
        logic        [stca_pkg::SIZE_W-1:0] len_x;
        logic        [stca_pkg::SIZE_W-1:0] len_y;
    } clip_t;

    function automatic axis_t clip_axis(
        input logic signed [stca_pkg::POS_W-1:0]  pos,
        input logic        [stca_pkg::SIZE_W-1:0] size,
        input logic signed [stca_pkg::POS_W-1:0]  lo,
        input logic signed [stca_pkg::POS_W-1:0]  hi
    );
        logic signed [stca_pkg::POS_W+1:0] p;
        logic signed [stca_pkg::POS_W+1:0] e;
        logic signed [stca_pkg::POS_W+1:0] l;
        logic signed [stca_pkg::POS_W+1:0] h;
        logic signed [stca_pkg::POS_W+1:0] d;
        axis_t r;
        p = {{2{pos[stca_pkg::POS_W-1]}}, pos};
        l = {{2{lo[stca_pkg::POS_W-1]}}, lo};
        h = {{2{hi[stca_pkg::POS_W-1]}}, hi};
        e = p + {{(stca_pkg::POS_W + 2 - stca_pkg::SIZE_W){1'b0}}, size};
        r.vis = !((e <= l) || (p >= h));
        r.dst = pos;
        r.off = '0;
        r.len = size;
        if (p < l)
        begin
            d     = l - p;
            r.off = d[stca_pkg::SIZE_W-1:0];
            r.len = size - d[stca_pkg::SIZE_W-1:0];
            r.dst = lo;
        end
        else if (e > h)
        begin
            d     = h - p;
            r.len = d[stca_pkg::SIZE_W-1:0];
        end
        return r;
    endfunction

    logic [stca_pkg::SIZE_W-1:0] tile_width_reg;
    logic [stca_pkg::SIZE_W-1:0] tile_height_reg;
    logic [stca_pkg::GAP_W-1:0]  sheet_margin_reg;
    logic [stca_pkg::GAP_W-1:0]  tile_spacing_reg;
    logic [stca_pkg::PER_W-1:0]  tiles_per_row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_width_reg    <= stca_pkg::TILE_WIDTH_RST;
            tile_height_reg   <= stca_pkg::TILE_HEIGHT_RST;
            sheet_margin_reg  <= stca_pkg::SHEET_MARGIN_RST;
            tile_spacing_reg  <= stca_pkg::TILE_SPACING_RST;
            tiles_per_row_reg <= stca_pkg::TILES_PER_ROW_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                stca_pkg::CFG_TILE_WIDTH:
                    tile_width_reg <= cfg_wdata[stca_pkg::SIZE_W-1:0];
                stca_pkg::CFG_TILE_HEIGHT:
                    tile_height_reg <= cfg_wdata[stca_pkg::SIZE_W-1:0];
                stca_pkg::CFG_SHEET_MARGIN:
                    sheet_margin_reg <= cfg_wdata[stca_pkg::GAP_W-1:0];
                stca_pkg::CFG_TILE_SPACING:
                    tile_spacing_reg <= cfg_wdata[stca_pkg::GAP_W-1:0];
                stca_pkg::CFG_TILES_PER_ROW:
                    tiles_per_row_reg <= cfg_wdata[stca_pkg::PER_W-1:0];
                default:
                    ;
            endcase
        end
    end

    logic [stca_pkg::PER_W-1:0] divisor;
    assign divisor = (tiles_per_row_reg == '0) ? stca_pkg::PER_W'(1) : tiles_per_row_reg;

    // Each stage moves on when it is empty or the stage after it moves on.
    logic [NST-1:0] v_reg;
    logic [NST-1:0] v_next;
    logic [NST:0]   rdy;

    always_comb
    begin
        rdy[NST] = m_axis_tready;
        for (int k = NST - 1; k >= 0; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
        v_next[0] = rdy[0] ? s_axis_tvalid : v_reg[0];
        for (int k = 1; k < NST; k++)
        begin
            if (!rdy[k])
                v_next[k] = v_reg[k];
            else
                v_next[k] = v_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign s_axis_tready = rdy[0];

    req_t in_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[0])
            in_reg <= req_t'(s_axis_tdata[$bits(req_t)-1:0]);
    end

    clip_t clip_next;
    clip_t clip_reg [DIV_STAGES];

    always_comb
    begin
        axis_t ax;
        axis_t ay;
        ax = clip_axis(in_reg.pos_x, tile_width_reg, in_reg.clip_left, in_reg.clip_right);
        ay = clip_axis(in_reg.pos_y, tile_height_reg, in_reg.clip_top, in_reg.clip_bottom);
        clip_next.vis   = ax.vis && ay.vis;
        clip_next.dst_x = ax.dst;
        clip_next.dst_y = ay.dst;
        clip_next.off_x = ax.off;
        clip_next.off_y = ay.off;
        clip_next.len_x = ax.len;
        clip_next.len_y = ay.len;
    end

    genvar j;
    generate
        for (j = 0; j < DIV_STAGES; j++)
        begin : g_clip
            always_ff @(posedge clk)
            begin
                if (rdy[j+1])
                begin
                    if (j == 0)
                        clip_reg[j] <= clip_next;
                    else
                        clip_reg[j] <= clip_reg[(j == 0) ? 0 : j-1];
                end
            end
        end
    endgenerate

    logic [stca_pkg::IDX_W-1:0] row;
    logic [stca_pkg::PER_W-1:0] col;

    stca_div #(
        .STAGES (DIV_STAGES)
    ) u_div (
        .clk       (clk),
        .adv       (rdy[DIV_STAGES:1]),
        .dividend  (in_reg.tile_index),
        .divisor   (divisor),
        .quotient  (row),
        .remainder (col)
    );

    logic [STEP_W-1:0]           step_x;
    logic [STEP_W-1:0]           step_y;
    logic [stca_pkg::ADDR_W-1:0] prod_x_reg;
    logic [stca_pkg::ADDR_W-1:0] prod_y_reg;
    clip_t                       mclip_reg;

    assign step_x = STEP_W'(tile_spacing_reg) + STEP_W'(tile_width_reg);
    assign step_y = STEP_W'(tile_spacing_reg) + STEP_W'(tile_height_reg);

    // The remainder never exceeds the tile index, so it fits the index width.
    always_ff @(posedge clk)
    begin
        if (rdy[MUL])
        begin
            prod_x_reg <= stca_pkg::ADDR_W'(step_x)
                        * stca_pkg::ADDR_W'(col[stca_pkg::IDX_W-1:0]);
            prod_y_reg <= stca_pkg::ADDR_W'(step_y) * stca_pkg::ADDR_W'(row);
            mclip_reg  <= clip_reg[DIV_STAGES-1];
        end
    end

    logic                               vis_reg;
    logic signed [stca_pkg::POS_W-1:0]  dest_x_reg;
    logic signed [stca_pkg::POS_W-1:0]  dest_y_reg;
    logic        [stca_pkg::ADDR_W-1:0] src_x_reg;
    logic        [stca_pkg::ADDR_W-1:0] src_y_reg;
    logic        [stca_pkg::SIZE_W-1:0] src_w_reg;
    logic        [stca_pkg::SIZE_W-1:0] src_h_reg;
    logic        [stca_pkg::ADDR_W-1:0] src_x_next;
    logic        [stca_pkg::ADDR_W-1:0] src_y_next;

    assign src_x_next = prod_x_reg + stca_pkg::ADDR_W'(sheet_margin_reg)
                      + stca_pkg::ADDR_W'(mclip_reg.off_x);
    assign src_y_next = prod_y_reg + stca_pkg::ADDR_W'(sheet_margin_reg)
                      + stca_pkg::ADDR_W'(mclip_reg.off_y);

    always_ff @(posedge clk)
    begin
        if (rdy[LAST])
        begin
            vis_reg <= mclip_reg.vis;
            if (mclip_reg.vis)
            begin
                dest_x_reg <= mclip_reg.dst_x;
                dest_y_reg <= mclip_reg.dst_y;
                src_x_reg  <= src_x_next;
                src_y_reg  <= src_y_next;
                src_w_reg  <= mclip_reg.len_x;
                src_h_reg  <= mclip_reg.len_y;
            end
            else
            begin
                dest_x_reg <= '0;
                dest_y_reg <= '0;
                src_x_reg  <= '0;
                src_y_reg  <= '0;
                src_w_reg  <= '0;
                src_h_reg  <= '0;
            end
        end
    end

    assign m_axis_tvalid = v_reg[LAST];
    assign m_axis_tuser  = vis_reg;
    assign m_axis_tdata  = {2'b00, src_h_reg, src_w_reg, src_y_reg, src_x_reg,
                            dest_y_reg, dest_x_reg};

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> (m_axis_tdata == '0))
        else $error("Invisible result carries nonzero data.");

    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("Input stalled while the output stage is empty.");
`endif

endmodule

// ===== verif/sprite_tile_clip_address_unit_tb.sv =====
// Self-checking testbench for sprite_tile_clip_address_unit: random and directed blit requests,
// predicted clip rectangles and sheet addresses, random idling on both stream sides.
// Depends on stca_pkg and the unit's RTL.
module sprite_tile_clip_address_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import stca_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 2 * (DIV_STAGES + 3) + 4;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 135;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [3:0]               pad;
        logic signed [POS_W-1:0]  clip_bottom;
        logic signed [POS_W-1:0]  clip_right;
        logic signed [POS_W-1:0]  clip_top;
        logic signed [POS_W-1:0]  clip_left;
        logic [IDX_W-1:0]         tile_index;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [POS_W-1:0]  pos_x;
    } request_word_t;

    typedef struct packed {
        logic [1:0]               pad;
        logic [SIZE_W-1:0]        src_h;
        logic [SIZE_W-1:0]        src_w;
        logic [ADDR_W-1:0]        src_y;
        logic [ADDR_W-1:0]        src_x;
        logic signed [POS_W-1:0]  dest_y;
        logic signed [POS_W-1:0]  dest_x;
    } result_word_t;

    typedef struct {
        logic         visible;
        result_word_t word;
    } blit_rect_t;

    class blit_rect_tracker;
        logic [SIZE_W-1:0] tile_w;
        logic [SIZE_W-1:0] tile_h;
        logic [GAP_W-1:0]  margin;
        logic [GAP_W-1:0]  spacing;
        logic [PER_W-1:0]  per_row;
        blit_rect_t        pending_rects[$];
        int                failures;

        function new();
            tile_w   = TILE_WIDTH_RST;
            tile_h   = TILE_HEIGHT_RST;
            margin   = SHEET_MARGIN_RST;
            spacing  = TILE_SPACING_RST;
            per_row  = TILES_PER_ROW_RST;
            failures = 0;
        endfunction

        function void apply_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                CFG_TILE_WIDTH:    tile_w  = data[SIZE_W-1:0];
                CFG_TILE_HEIGHT:   tile_h  = data[SIZE_W-1:0];
                CFG_SHEET_MARGIN:  margin  = data[GAP_W-1:0];
                CFG_TILE_SPACING:  spacing = data[GAP_W-1:0];
                CFG_TILES_PER_ROW: per_row = data[PER_W-1:0];
                default: ;
            endcase
        endfunction

        // One axis is clipped on its low side if it starts before the box, else on its high side.
        function bit clip_span(longint pos, longint size, longint lo, longint hi,
                               output longint start, output longint skip, output longint span);
            start = pos;
            skip  = 0;
            span  = size;
            if (pos + size <= lo || pos >= hi)
                return 1'b0;
            if (pos < lo)
            begin
                skip  = lo - pos;
                span  = size - skip;
                start = lo;
            end
            else if (pos + size > hi)
                span = hi - pos;
            return 1'b1;
        endfunction

        function void note_request(request_word_t r);
            blit_rect_t            e;
            longint                dx, dy, ox, oy, w, h;
            longint unsigned       per, col, row, sx, sy;
            e.visible = 1'b0;
            e.word    = '0;
            if (clip_span(r.pos_x, longint'(tile_w), r.clip_left, r.clip_right, dx, ox, w) &&
                clip_span(r.pos_y, longint'(tile_h), r.clip_top, r.clip_bottom, dy, oy, h))
            begin
                per = (per_row == 0) ? 64'd1 : 64'(per_row);
                col = 64'(r.tile_index) % per;
                row = 64'(r.tile_index) / per;
                sx  = 64'(margin) + (64'(spacing) + 64'(tile_w)) * col;
                sy  = 64'(margin) + (64'(spacing) + 64'(tile_h)) * row;
                e.visible     = 1'b1;
                e.word.dest_x = POS_W'(dx);
                e.word.dest_y = POS_W'(dy);
                e.word.src_x  = ADDR_W'(sx + 64'(ox));
                e.word.src_y  = ADDR_W'(sy + 64'(oy));
                e.word.src_w  = SIZE_W'(w);
                e.word.src_h  = SIZE_W'(h);
            end
            pending_rects.push_back(e);
        endfunction

        function string describe(blit_rect_t r);
            return $sformatf("visible=%0b dest=(%0d,%0d) src=(%0d,%0d) size=%0dx%0d",
                             r.visible, r.word.dest_x, r.word.dest_y, r.word.src_x,
                             r.word.src_y, r.word.src_w, r.word.src_h);
        endfunction

        function void report_failure(string msg);
            failures++;
            if (failures <= MAX_REPORTS)
                $display("%0t: mismatch: %s", $time, msg);
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data, logic visible);
            blit_rect_t a, e;
            a.visible = visible;
            a.word    = result_word_t'(data);
            if (pending_rects.size() == 0)
            begin
                report_failure($sformatf("result with nothing expected: %s", describe(a)));
                return;
            end
            e = pending_rects.pop_front();
            if (a.visible !== e.visible || a.word.dest_x !== e.word.dest_x ||
                a.word.dest_y !== e.word.dest_y || a.word.src_x !== e.word.src_x ||
                a.word.src_y !== e.word.src_y || a.word.src_w !== e.word.src_w ||
                a.word.src_h !== e.word.src_h)
                report_failure($sformatf("expected %s, got %s", describe(e), describe(a)));
        endfunction

        function int pending();
            return pending_rects.size();
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic [0:0]             m_axis_tuser;

    blit_rect_tracker       sb;
    int                     send_idle_pct = 0;
    int                     stall_pct = 0;
    bit                     long_hold = 1'b0;
    int                     cycle_count = 0;

    sprite_tile_clip_address_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_wr_en)
                sb.apply_register(cfg_index, cfg_wdata);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_request(request_word_t'(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tuser[0]);
        end
    end

    // The long hold keeps the output stalled so that the pipeline fills and backs up.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                long_hold = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_request(request_word_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= r;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    task automatic configure(int tw, int th, int mg, int sp, int tpr);
        write_register(CFG_TILE_WIDTH, tw);
        write_register(CFG_TILE_HEIGHT, th);
        write_register(CFG_SHEET_MARGIN, mg);
        write_register(CFG_TILE_SPACING, sp);
        write_register(CFG_TILES_PER_ROW, tpr);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_idling(int mode);
        case (mode)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 49; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 49; end
            default: begin send_idle_pct = 13; stall_pct = 13; end
        endcase
    endtask

    function automatic request_word_t make_request(int px, int py, int idx,
                                                   int cl, int ct, int cr, int cb);
        request_word_t r;
        r             = '0;
        r.pos_x       = px;
        r.pos_y       = py;
        r.tile_index  = idx;
        r.clip_left   = cl;
        r.clip_top    = ct;
        r.clip_right  = cr;
        r.clip_bottom = cb;
        return r;
    endfunction

    // Most requests straddle the edges of a random box; some boxes are inverted, some
    // requests are fully random.
    function automatic request_word_t random_request(int size_x, int size_y);
        request_word_t r;
        int            kind, span_x, span_y;
        kind         = $urandom_range(99);
        r            = '0;
        r.tile_index = ($urandom_range(3) == 0) ? IDX_W'($urandom_range(15)) : IDX_W'($urandom);
        if (kind < 15)
        begin
            r.pos_x       = $urandom;
            r.pos_y       = $urandom;
            r.clip_left   = $urandom;
            r.clip_top    = $urandom;
            r.clip_right  = $urandom;
            r.clip_bottom = $urandom;
        end
        else
        begin
            span_x        = $urandom_range(1) ? $urandom_range(400) : $urandom_range(20);
            span_y        = $urandom_range(1) ? $urandom_range(400) : $urandom_range(20);
            r.clip_left   = $urandom;
            r.clip_top    = $urandom;
            r.clip_right  = (kind < 25) ? r.clip_left - $urandom_range(1, 40) : r.clip_left + span_x;
            r.clip_bottom = (kind < 25) ? r.clip_top - $urandom_range(1, 40) : r.clip_top + span_y;
            r.pos_x       = r.clip_left - size_x - 2 + $urandom_range(span_x + size_x + 4);
            r.pos_y       = r.clip_top - size_y - 2 + $urandom_range(span_y + size_y + 4);
        end
        return r;
    endfunction

    initial
    begin
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idling(0);
        send_request(make_request(10, 10, 0, 0, 0, 100, 100));
        send_request(make_request(-5, 10, 1, 0, 0, 100, 100));
        send_request(make_request(10, -7, 2, 0, 0, 100, 100));
        send_request(make_request(90, 10, 3, 0, 0, 100, 100));
        send_request(make_request(10, 95, 4, 0, 0, 100, 100));
        send_request(make_request(-4, -4, 5, 0, 0, 8, 8));
        send_request(make_request(-16, 10, 6, 0, 0, 100, 100));
        send_request(make_request(100, 10, 6, 0, 0, 100, 100));
        send_request(make_request(10, -16, 6, 0, 0, 100, 100));
        send_request(make_request(10, 100, 6, 0, 0, 100, 100));
        send_request(make_request(10, 10, 7, 100, 100, 0, 0));
        send_request(make_request(10, 10, 9, 20, 20, 15, 15));
        send_request(make_request(32760, 32760, 4095, 32750, 32750, 32767, 32767));
        send_request(make_request(-32768, -32768, 4095, -32768, -32768, 32767, 32767));
        send_request(make_request(-32768, -32768, 0, -32768, -32768, -32768, -32768));
        send_request(make_request(0, 0, 0, 0, 0, 0, 0));
        send_request(make_request(-1, -1, 4095, -1, -1, -1, -1));
        send_request(make_request(-20, -20, 4095, -32768, -32768, -8, -8));
        send_request(make_request(32767, -32768, 100, -32768, -32768, 32767, 32767));
        send_request(make_request(0, 0, 2048, 1, 1, 2, 2));

        for (int phase = 1; phase <= 8; phase++)
        begin
            wait_drained();
            case (phase)
                1: configure(1, 1, 0, 0, 0);
                2:
                begin
                    for (int i = CFG_TILES_PER_ROW + 1; i < 2 ** CFG_IDX_W; i++)
                        write_register(i, '1);
                    configure(511, 511, 255, 255, 8191);
                end
                3: configure(0, 40, 3, 1, 7);
                4: configure(256, 256, 255, 255, 4096);
                default:
                    configure($urandom_range(3) ? $urandom_range(1, 64) : $urandom_range(511),
                              $urandom_range(3) ? $urandom_range(1, 64) : $urandom_range(511),
                              $urandom_range(255) | ($urandom_range(31) << GAP_W),
                              $urandom_range(255) | ($urandom_range(31) << GAP_W),
                              $urandom_range(3) ? $urandom_range(1, 100) : $urandom_range(8191));
            endcase
            set_idling(phase % 4);
            if (phase == 4)
                long_hold = 1'b1;
            repeat (PHASE_ITEMS) send_request(random_request(sb.tile_w, sb.tile_h));
        end

        wait_drained();
        if (sb.failures == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
